@@ design/vls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler package
// Shared widths, operation codes, payload types and small helpers.
// ----------------------------------------------------------------------------
package vls_pkg;

   // Default number of fraction bits of the fixed-point format
   localparam int FRAC_BITS_DEF = 16;

   localparam int COMP_W = 32;   // component and amount width
   localparam int EPS_W  = 17;   // epsilon register width
   localparam int SQ_W   = 64;   // squared length width
   localparam int ROOT_W = 32;   // length width (floor square root)
   localparam int REM_W  = 34;   // square root partial remainder width
   localparam int MUL_W  = 33;   // scale multiplier magnitude width
   localparam int NUM_W  = 66;   // rounded numerator width

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

   // Operation codes
   localparam logic [1:0] OP_NORMALIZE  = 2'd0;
   localparam logic [1:0] OP_CLAMP      = 2'd1;
   localparam logic [1:0] OP_ADD_LENGTH = 2'd2;
   localparam logic [1:0] OP_RESERVED   = 2'd3;   // unused, vector passes unchanged

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [COMP_W-1:0] vec_x;
      logic signed [COMP_W-1:0] vec_y;
      logic signed [COMP_W-1:0] vec_z;
      logic signed [COMP_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic                     degenerate;
      logic                     saturated;
   } rsp_type;

   // Item data carried alongside the square root pipeline
   typedef struct packed {
      logic [1:0]               operation;
      logic signed [COMP_W-1:0] vec_x;
      logic signed [COMP_W-1:0] vec_y;
      logic signed [COMP_W-1:0] vec_z;
      logic signed [COMP_W-1:0] amount;
      logic [SQ_W-1:0]          amount_sq;
      logic [SQ_W-1:0]          len_sq;
   } root_pay_type;

   // Scale control shared by all lanes
   typedef struct packed {
      logic              do_scale;
      logic              negate;
      logic [MUL_W-1:0]  mul;
      logic [ROOT_W-1:0] len;
      logic              degenerate;
   } scale_ctl_type;

   // Magnitude of a signed component; the most negative value maps to 2^31
   function automatic logic [COMP_W-1:0] mag32(input logic signed [COMP_W-1:0] v);
      logic [COMP_W-1:0] r;
      r = v[COMP_W-1] ? COMP_W'(-v) : COMP_W'(v);
      return r;
   endfunction

endpackage

@@ design/vector_length_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler
// Normalizes, clamps or extends the length of a signed fixed-point 3D vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one vector is accepted per clock while req_stall is low
// (71 register stages: input register, squares, sum, 32 square root stages,
// operation decode, 34 stages of per-component multiply, 32-stage rounding
// divide and saturation in three parallel lanes, then the result register).
// The result register lets the pipeline keep accepting vectors while a result
// is stalled until a finished vector reaches the end of the pipeline. Epsilon
// is written through the csr_ port and must only change while the block is
// empty.
// ----------------------------------------------------------------------------
module vector_length_scaler #(
   parameter int FRAC_BITS = vls_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  vls_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vls_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [vls_pkg::EPS_W-1:0]       csr_write_data
);

   localparam int COMP_W = vls_pkg::COMP_W;
   localparam int SQ_W   = vls_pkg::SQ_W;
   localparam int ROOT_W = vls_pkg::ROOT_W;
   localparam int MUL_W  = vls_pkg::MUL_W;
   localparam int EPS_W  = vls_pkg::EPS_W;

   logic advance;
   logic lane_valid [3];
   logic lane_degen [3];
   logic signed [COMP_W-1:0] lane_comp [3];
   logic [2:0] lane_sat;

   // pipeline moves unless a finished vector would hit a stalled result
   assign advance   = !(rsp_valid && rsp_stall && lane_valid[0]);
   assign req_stall = !advance;

   // epsilon register
   logic [EPS_W-1:0] epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= vls_pkg::EPS_RESET;
      end else if (csr_write_enable) begin
         epsilon_ff <= csr_write_data;
      end
   end

   // input register
   logic             a_valid_ff;
   vls_pkg::req_type a_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_data_ff <= req_data;
      end
   end

   // squares of the component magnitudes and of the amount
   logic             b_valid_ff;
   vls_pkg::req_type b_data_ff;
   logic [SQ_W-1:0]  b_sq_ff [3];
   logic [SQ_W-1:0]  b_amount_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_data_ff      <= a_data_ff;
         b_sq_ff[0]     <= SQ_W'(vls_pkg::mag32(a_data_ff.vec_x))
                         * SQ_W'(vls_pkg::mag32(a_data_ff.vec_x));
         b_sq_ff[1]     <= SQ_W'(vls_pkg::mag32(a_data_ff.vec_y))
                         * SQ_W'(vls_pkg::mag32(a_data_ff.vec_y));
         b_sq_ff[2]     <= SQ_W'(vls_pkg::mag32(a_data_ff.vec_z))
                         * SQ_W'(vls_pkg::mag32(a_data_ff.vec_z));
         b_amount_sq_ff <= SQ_W'(vls_pkg::mag32(a_data_ff.amount))
                         * SQ_W'(vls_pkg::mag32(a_data_ff.amount));
      end
   end

   // squared length sum
   logic                  c_valid_ff;
   vls_pkg::root_pay_type c_pay_ff, c_pay_in;

   always_comb begin
      c_pay_in.operation = b_data_ff.operation;
      c_pay_in.vec_x     = b_data_ff.vec_x;
      c_pay_in.vec_y     = b_data_ff.vec_y;
      c_pay_in.vec_z     = b_data_ff.vec_z;
      c_pay_in.amount    = b_data_ff.amount;
      c_pay_in.amount_sq = b_amount_sq_ff;
      c_pay_in.len_sq    = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_pay_ff <= c_pay_in;
      end
   end

   // length
   logic                  r_valid;
   logic [ROOT_W-1:0]     r_len;
   vls_pkg::root_pay_type r_pay;

   vls_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c_valid_ff),
      .in_pay    (c_pay_ff),
      .out_valid (r_valid),
      .out_root  (r_len),
      .out_pay   (r_pay)
   );

   // operation decode
   logic                     d_valid_ff;
   vls_pkg::scale_ctl_type   d_ctl_ff, d_ctl_in;
   logic signed [COMP_W-1:0] d_comp_ff [3];
   logic signed [COMP_W-1:0] d_comp_in [3];
   logic signed [COMP_W+1:0] total_len;
   logic [SQ_W-1:0]          eps_sq_guard;

   assign total_len    = (COMP_W+2)'(r_len) + (COMP_W+2)'(r_pay.amount);
   assign eps_sq_guard = SQ_W'(epsilon_ff) << FRAC_BITS;

   always_comb begin
      d_ctl_in.do_scale   = 1'b0;
      d_ctl_in.negate     = 1'b0;
      d_ctl_in.mul        = '0;
      d_ctl_in.len        = r_len;
      d_ctl_in.degenerate = 1'b0;
      d_comp_in[0]        = r_pay.vec_x;
      d_comp_in[1]        = r_pay.vec_y;
      d_comp_in[2]        = r_pay.vec_z;
      case (r_pay.operation)
         vls_pkg::OP_NORMALIZE: begin
            if (r_pay.len_sq < eps_sq_guard || r_len == '0) begin
               d_ctl_in.degenerate = 1'b1;
               d_comp_in[0]        = '0;
               d_comp_in[1]        = '0;
               d_comp_in[2]        = '0;
            end else begin
               d_ctl_in.do_scale = 1'b1;
               d_ctl_in.mul      = MUL_W'(1) << FRAC_BITS;
            end
         end
         vls_pkg::OP_CLAMP: begin
            if (r_pay.len_sq > r_pay.amount_sq && r_len != '0) begin
               d_ctl_in.do_scale = 1'b1;
               d_ctl_in.mul      = MUL_W'(vls_pkg::mag32(r_pay.amount));
               d_ctl_in.negate   = r_pay.amount[COMP_W-1];
            end
         end
         vls_pkg::OP_ADD_LENGTH: begin
            if (r_len > ROOT_W'(epsilon_ff)) begin
               d_ctl_in.do_scale = 1'b1;
               d_ctl_in.negate   = total_len[COMP_W+1];
               d_ctl_in.mul      = total_len[COMP_W+1] ? MUL_W'(-total_len)
                                                       : MUL_W'(total_len);
            end else begin
               d_ctl_in.degenerate = 1'b1;
            end
         end
         default: begin
            d_ctl_in.do_scale = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ctl_ff     <= d_ctl_in;
         d_comp_ff[0] <= d_comp_in[0];
         d_comp_ff[1] <= d_comp_in[1];
         d_comp_ff[2] <= d_comp_in[2];
      end
   end

   // one lane per component
   for (genvar i = 0; i < 3; i++) begin : g_lane
      vls_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .in_valid       (d_valid_ff),
         .in_comp        (d_comp_ff[i]),
         .in_ctl         (d_ctl_ff),
         .out_valid      (lane_valid[i]),
         .out_degenerate (lane_degen[i]),
         .out_comp       (lane_comp[i]),
         .out_saturated  (lane_sat[i])
      );
   end

   vls_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .lane_valid      (lane_valid[0]),
      .lane_degenerate (lane_degen[0]),
      .lane_comp       (lane_comp),
      .lane_saturated  (lane_sat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

   // lanes run in lock step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] == lane_valid[1] && lane_valid[0] == lane_valid[2])
      else $error("lane valids disagree");

   // input is held back only by a stalled result with another one behind it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && lane_valid[0]))
      else $error("input stalled without cause");

endmodule

@@ design/vls_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler square root
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vls_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  vls_pkg::root_pay_type        in_pay,
   output logic                         out_valid,
   output logic [vls_pkg::ROOT_W-1:0]   out_root,
   output vls_pkg::root_pay_type        out_pay
);

   localparam int STAGES = vls_pkg::ROOT_W;
   localparam int REM_W  = vls_pkg::REM_W;
   localparam int ROOT_W = vls_pkg::ROOT_W;
   localparam int SQ_W   = vls_pkg::SQ_W;

   logic                  valid_ff [STAGES];
   logic [REM_W-1:0]      rem_ff   [STAGES];
   logic [ROOT_W-1:0]     root_ff  [STAGES];
   logic [SQ_W-1:0]       bits_ff  [STAGES];
   vls_pkg::root_pay_type pay_ff   [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                  valid_prev;
      logic [REM_W-1:0]      rem_prev, rem_shift, trial, rem_in;
      logic [ROOT_W-1:0]     root_prev, root_in;
      logic [SQ_W-1:0]       bits_prev;
      vls_pkg::root_pay_type pay_prev;
      logic                  ge;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign bits_prev  = in_pay.len_sq;
         assign pay_prev   = in_pay;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign bits_prev  = bits_ff[k-1];
         assign pay_prev   = pay_ff[k-1];
      end

      // bring down two radicand bits, try subtracting 4*root + 1
      assign rem_shift = {rem_prev[REM_W-3:0], bits_prev[SQ_W-1 -: 2]};
      assign trial     = {root_prev, 2'b01};
      assign ge        = rem_shift >= trial;
      assign rem_in    = ge ? rem_shift - trial : rem_shift;
      assign root_in   = {root_prev[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            bits_ff[k] <= bits_prev << 2;
            pay_ff[k]  <= pay_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_pay   = pay_ff[STAGES-1];

endmodule

@@ design/vls_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler lane
// Scales one component: multiply, pipelined rounding divide, saturation.
// ----------------------------------------------------------------------------
module vls_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [vls_pkg::COMP_W-1:0] in_comp,
   input  vls_pkg::scale_ctl_type        in_ctl,
   output logic                          out_valid,
   output logic                          out_degenerate,
   output logic signed [vls_pkg::COMP_W-1:0] out_comp,
   output logic                          out_saturated
);

   localparam int COMP_W = vls_pkg::COMP_W;
   localparam int NUM_W  = vls_pkg::NUM_W;
   localparam int STAGES = COMP_W;

   typedef struct packed {
      logic                     negative;
      logic                     overflow;
      logic signed [COMP_W-1:0] comp;
      vls_pkg::scale_ctl_type   ctl;
   } meta_type;

   // ---- multiply stage: |c| * mul + len/2 ----
   logic                     mul_valid_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [NUM_W-1:0]         num_in;
   logic signed [COMP_W-1:0] mul_comp_ff;
   vls_pkg::scale_ctl_type   mul_ctl_ff;

   assign num_in = NUM_W'(vls_pkg::mag32(in_comp)) * NUM_W'(in_ctl.mul)
                 + NUM_W'(in_ctl.len >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff      <= num_in;
         mul_comp_ff <= in_comp;
         mul_ctl_ff  <= in_ctl;
      end
   end

   // ---- divide stages: one quotient bit per stage ----
   logic              valid_ff [STAGES];
   logic [COMP_W-1:0] rem_ff   [STAGES];
   logic [COMP_W-1:0] low_ff   [STAGES];
   logic [COMP_W-1:0] quo_ff   [STAGES];
   meta_type          meta_ff  [STAGES];

   meta_type meta_first;

   // quotient of 2^32 or more saturates whatever the sign
   always_comb begin
      meta_first.negative = mul_comp_ff[COMP_W-1] ^ mul_ctl_ff.negate;
      meta_first.overflow = num_ff[NUM_W-1:COMP_W] >= (NUM_W-COMP_W)'(mul_ctl_ff.len);
      meta_first.comp     = mul_comp_ff;
      meta_first.ctl      = mul_ctl_ff;
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_div
      logic              valid_prev;
      logic [COMP_W-1:0] rem_prev, low_prev, quo_prev, rem_in;
      logic [COMP_W:0]   rem_shift, divisor;
      meta_type          meta_prev;
      logic              ge;

      if (k == 0) begin : g_first
         assign valid_prev = mul_valid_ff;
         assign rem_prev   = num_ff[2*COMP_W-1:COMP_W];
         assign low_prev   = num_ff[COMP_W-1:0];
         assign quo_prev   = '0;
         assign meta_prev  = meta_first;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign meta_prev  = meta_ff[k-1];
      end

      assign rem_shift = {rem_prev, low_prev[COMP_W-1]};
      assign divisor   = (COMP_W+1)'(meta_prev.ctl.len);
      assign ge        = rem_shift >= divisor;
      assign rem_in    = ge ? COMP_W'(rem_shift - divisor) : rem_shift[COMP_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= low_prev << 1;
            quo_ff[k]  <= {quo_prev[COMP_W-2:0], ge};
            meta_ff[k] <= meta_prev;
         end
      end
   end

   // ---- sign and saturation stage ----
   localparam logic [COMP_W-1:0] POS_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] NEG_MAG = {1'b1, {(COMP_W-1){1'b0}}};

   meta_type          meta_last;
   logic [COMP_W-1:0] quo_last;
   logic [COMP_W-1:0] comp_in;
   logic              sat_in;
   logic              out_valid_ff, out_degen_ff, out_sat_ff;
   logic [COMP_W-1:0] out_comp_ff;

   assign meta_last = meta_ff[STAGES-1];
   assign quo_last  = quo_ff[STAGES-1];

   always_comb begin
      comp_in = meta_last.comp;
      sat_in  = 1'b0;
      if (meta_last.ctl.do_scale) begin
         if (meta_last.negative) begin
            if (meta_last.overflow || quo_last > NEG_MAG) begin
               comp_in = NEG_MAG;
               sat_in  = 1'b1;
            end else begin
               comp_in = COMP_W'(-quo_last);
            end
         end else begin
            if (meta_last.overflow || quo_last > POS_MAX) begin
               comp_in = POS_MAX;
               sat_in  = 1'b1;
            end else begin
               comp_in = quo_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_comp_ff  <= comp_in;
         out_sat_ff   <= sat_in;
         out_degen_ff <= meta_last.ctl.degenerate;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_comp       = out_comp_ff;
   assign out_saturated  = out_sat_ff;
   assign out_degenerate = out_degen_ff;

endmodule

@@ design/vls_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler merge
// Gathers the three lane results into one result register and its handshake.
// ----------------------------------------------------------------------------
module vls_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              lane_valid,
   input  logic                              lane_degenerate,
   input  logic signed [vls_pkg::COMP_W-1:0] lane_comp [3],
   input  logic [2:0]                        lane_saturated,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output vls_pkg::rsp_type                  rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   vls_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // combine lanes: any clipped component flags the vector
   always_comb begin
      rsp_data_in.out_x      = lane_comp[0];
      rsp_data_in.out_y      = lane_comp[1];
      rsp_data_in.out_z      = lane_comp[2];
      rsp_data_in.degenerate = lane_degenerate;
      rsp_data_in.saturated  = |lane_saturated;
   end

   // result register: loads on advance, empties when its transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = lane_valid | (rsp_valid_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && lane_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an unscaled vector can never clip
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.degenerate && rsp_data.saturated))
      else $error("degenerate and saturated both set");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

@@ dv/vls_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler checker
// Watches the request, response and csr ports of the scaler, predicts each
// rescaled vector from the accepted request and the current epsilon, and
// compares every response transfer field by field, oldest first.
// ----------------------------------------------------------------------------
module vls_checker #(
   parameter int FRAC_BITS = vls_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  vls_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  vls_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_enable,
   input  logic [vls_pkg::EPS_W-1:0] csr_write_data,
   output int                        fail_count,
   output int                        pending_count
);

   vls_pkg::rsp_type          scaled_queue[$];
   logic [vls_pkg::EPS_W-1:0] eps_shadow;
   int                        fails = 0;

   // Floor square root, bit by bit
   function automatic longint unsigned floor_root(input longint unsigned s);
      longint unsigned rem, res, bitv;
      rem  = s;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // round(comp * (+/-mul) / len), halves away from zero, saturated
   function automatic logic [31:0] rescale(input longint signed comp,
                                           input longint unsigned mul,
                                           input bit mul_neg,
                                           input longint unsigned len,
                                           inout bit sat);
      longint unsigned m;
      bit neg;
      m   = (comp < 0) ? longint'(-comp) : comp;
      m   = (m * mul + len / 2) / len;
      neg = (comp < 0) != mul_neg;
      if (neg) begin
         if (m > 64'h8000_0000) begin
            m   = 64'h8000_0000;
            sat = 1'b1;
         end
         return 32'(64'd0 - m);
      end
      if (m > 64'h7FFF_FFFF) begin
         m   = 64'h7FFF_FFFF;
         sat = 1'b1;
      end
      return 32'(m);
   endfunction

   function automatic vls_pkg::rsp_type predict_scaled(input vls_pkg::req_type r,
                                                      input logic [vls_pkg::EPS_W-1:0] eps);
      vls_pkg::rsp_type p;
      longint signed    v[3];
      longint signed    amt, tot;
      longint unsigned  sq, len, mul, am, m;
      bit               neg, sat, degen, do_scale;
      v[0] = r.vec_x;
      v[1] = r.vec_y;
      v[2] = r.vec_z;
      amt  = r.amount;
      sq   = 0;
      mul  = 0;
      neg  = 0;
      sat  = 0;
      degen = 0;
      do_scale = 0;
      for (int i = 0; i < 3; i++) begin
         m  = (v[i] < 0) ? longint'(-v[i]) : v[i];
         sq = sq + m * m;
      end
      len = floor_root(sq);
      case (r.operation)
         vls_pkg::OP_NORMALIZE: begin
            if (sq < (longint'(eps) << FRAC_BITS) || len == 0) begin
               degen = 1;
               for (int i = 0; i < 3; i++) v[i] = 0;
            end else begin
               do_scale = 1;
               mul = 64'd1 << FRAC_BITS;
            end
         end
         vls_pkg::OP_CLAMP: begin
            am = (amt < 0) ? longint'(-amt) : amt;
            if (sq > am * am && len != 0) begin
               do_scale = 1;
               mul = am;
               neg = amt < 0;
            end
         end
         vls_pkg::OP_ADD_LENGTH: begin
            if (len > eps) begin
               tot = longint'(len) + amt;
               do_scale = 1;
               mul = (tot < 0) ? longint'(-tot) : tot;
               neg = tot < 0;
            end else begin
               degen = 1;
            end
         end
         default: ;
      endcase
      if (do_scale) begin
         p.out_x = rescale(v[0], mul, neg, len, sat);
         p.out_y = rescale(v[1], mul, neg, len, sat);
         p.out_z = rescale(v[2], mul, neg, len, sat);
      end else begin
         p.out_x = 32'(v[0]);
         p.out_y = 32'(v[1]);
         p.out_z = 32'(v[2]);
      end
      p.degenerate = degen;
      p.saturated  = sat;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fails++;
   endtask

   assign fail_count = fails;

   // Track epsilon, queue predictions and compare response transfers
   always @(posedge clock) begin
      vls_pkg::rsp_type want;
      if (reset) begin
         eps_shadow    <= vls_pkg::EPS_RESET;
         pending_count <= 0;
      end else begin
         if (csr_write_enable) eps_shadow <= csr_write_data;
         if (req_valid && !req_stall)
            scaled_queue.push_back(predict_scaled(req_data, eps_shadow));
         if (rsp_valid && !rsp_stall) begin
            if (scaled_queue.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.out_x, 0);
            end else begin
               want = scaled_queue.pop_front();
               if (rsp_data.out_x !== want.out_x)
                  report_mismatch("out_x", rsp_data.out_x, want.out_x);
               if (rsp_data.out_y !== want.out_y)
                  report_mismatch("out_y", rsp_data.out_y, want.out_y);
               if (rsp_data.out_z !== want.out_z)
                  report_mismatch("out_z", rsp_data.out_z, want.out_z);
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_data.saturated, want.saturated);
            end
         end
         pending_count <= scaled_queue.size();
      end
   end

endmodule

@@ dv/vector_length_scaler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector length scaler testbench
// Drives directed and random vectors through the scaler under several
// epsilon settings and idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module vector_length_scaler_tb;

   localparam int LATENCY     = 71;
   localparam int CYCLE_LIMIT = 600000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   vls_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   vls_pkg::rsp_type          rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [vls_pkg::EPS_W-1:0] csr_write_data = '0;
   int                        fail_count;
   int                        pending_count;
   int                        cycle_count = 0;
   int                        idle_pct = 0;
   int                        stall_pct = 0;
   int                        hold_left = 0;
   int                        hold_token = 0;
   int                        hold_seen = 0;

   vector_length_scaler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   vls_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stall, or a long counted hold-off when requested
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [31:0] pick_comp();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'($signed($urandom_range(8191)) - 4096);
         3:       return 32'($signed($urandom_range(2097151)) - 1048576);
         4:       return 32'($signed($urandom_range(262143)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   function automatic vls_pkg::req_type random_vector();
      vls_pkg::req_type r;
      r.operation = ($urandom_range(19) == 0) ? vls_pkg::OP_RESERVED
                                              : 2'($urandom_range(2));
      r.vec_x  = pick_comp();
      r.vec_y  = pick_comp();
      r.vec_z  = pick_comp();
      r.amount = pick_comp();
      return r;
   endfunction

   function automatic vls_pkg::req_type make_vector(input logic [1:0] op,
                                                    input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] z,
                                                    input logic [31:0] amt);
      vls_pkg::req_type r;
      r.operation = op;
      r.vec_x  = x;
      r.vec_y  = y;
      r.vec_z  = z;
      r.amount = amt;
      return r;
   endfunction

   // One request transfer, with an optional idle gap before it
   task automatic send_vector(input vls_pkg::req_type r);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Drain, let the pipe empty, then write epsilon
   task automatic set_epsilon(input logic [vls_pkg::EPS_W-1:0] eps);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (LATENCY + 10) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= eps;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [vls_pkg::EPS_W-1:0] eps_list[5];
      int                        idle_list[5];
      int                        stall_list[5];
      eps_list   = '{17'd1, 17'd0, 17'd65536, 17'd300, 17'd12};
      idle_list  = '{0, 88, 0, 20, 0};
      stall_list = '{0, 0, 88, 20, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every operation, guards and special cases
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 0, 0, 0, 0));
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 0));
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 0));
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 1, 0, 0, 0));
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 256, 0, 0, 0));
      send_vector(make_vector(vls_pkg::OP_NORMALIZE, 32'h0001_0000, 32'hFFFF_0000, 3, 0));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 32'h0003_0000, 32'h0004_0000, 0,
                              32'h0001_0000));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 32'h0003_0000, 32'h0004_0000, 0,
                              32'hFFFF_0000));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 32'h0003_0000, 32'h0004_0000, 0,
                              32'h0005_0000));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 32'h0003_0000, 32'h0004_0000, 0,
                              32'h8000_0000));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 0, 0, 0, 0));
      send_vector(make_vector(vls_pkg::OP_CLAMP, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                              32'h7FFF_FFFF));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 32'h0003_0000, 32'h0004_0000, 0,
                              32'h0001_0000));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 1, 0, 0, 32'h0001_0000));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 32'h0003_0000, 0, 0,
                              32'hFFF0_0000));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 32'h4000_0000, 32'h4000_0000, 0,
                              32'h7FFF_FFFF));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000));
      send_vector(make_vector(vls_pkg::OP_ADD_LENGTH, 0, 0, 0, 32'h7FFF_FFFF));
      send_vector(make_vector(vls_pkg::OP_RESERVED, 32'h8000_0000, 32'h7FFF_FFFF, 5,
                              32'h1234_5678));

      // Random phases under different epsilon and idle/stall mixes
      for (int ph = 0; ph < 5; ph++) begin
         set_epsilon(eps_list[ph]);
         idle_pct  = idle_list[ph];
         stall_pct = stall_list[ph];
         for (int n = 0; n < 120; n++) begin
            if (ph == 0 && n == 20) hold_token <= hold_token + 1;
            send_vector(random_vector());
         end
      end

      // Wind down
      req_valid <= 1'b0;
      stall_pct = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
